/* sv/bts_pkg.sv */
// ----------------------------------------------------------------------------
// bts_pkg
// types and constants shared by the bilinear texture sampler files
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int SIDE_BITS = 6;
    localparam int CH_BITS   = 16;
    localparam int UV_BITS   = 24;
    localparam int SIZE_BITS = 7;
    localparam int IDX_BITS  = 2;

    localparam logic [SIZE_BITS-1:0] MAX_SIDE = 7'd64;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [IDX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_WRAP   = 2'd2;

    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic                       op;
        logic [SIDE_BITS-1:0]       tex_x;
        logic [SIDE_BITS-1:0]       tex_y;
        logic signed [CH_BITS-1:0]  in_red;
        logic signed [CH_BITS-1:0]  in_green;
        logic signed [CH_BITS-1:0]  in_blue;
        logic signed [CH_BITS-1:0]  in_alpha;
        logic signed [UV_BITS-1:0]  u_coord;
        logic signed [UV_BITS-1:0]  v_coord;
    } cmd_t;

    typedef struct packed {
        logic signed [CH_BITS-1:0]  out_red;
        logic signed [CH_BITS-1:0]  out_green;
        logic signed [CH_BITS-1:0]  out_blue;
        logic signed [CH_BITS-1:0]  out_alpha;
    } res_t;

endpackage

/* sv/bilinear_texture_sampler_top.sv */
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_top
// rgba texel store with a bilinear sampler, clamp or wrap addressing
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// command   in         start & !busy               cmd (cmd_t)
// result    out        result_valid, one cycle     result (res_t)
// config    in         cfg_valid & cfg_ready       cfg_index, cfg_data
//
// a store transaction writes in its accept cycle, busy stays low
// a sample transaction runs two scale multiplies, one setup, then per corner
// one fetch and four channel multiply-accumulates, then a finish step; the
// multiplies all use one shared 33x17 multiplier, the fetches the texel memory
// the result strobe shows in the cycle busy falls; the receiver cannot stall
// reset clears control state only; texel contents are undefined until written
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_top
    import bts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    output logic                 result_valid,
    output res_t                 result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_BITS-1:0]  cfg_index,
    input  logic [SIZE_BITS-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCALE_U, S_SCALE_V, S_SETUP, S_FETCH, S_MAC, S_FINISH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [SIZE_BITS-1:0] width_reg, height_reg;
    logic                 wrap_reg;

    // sample working registers
    logic [UV_BITS-1:0]   u_reg, v_reg;
    logic [22:0]          cu_reg, cv_reg;
    logic [SIDE_BITS-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [15:0]          fx_reg, fy_reg;
    logic [32:0]          weight_reg;
    logic [1:0]           corner_reg, ch_reg;
    logic [48:0]          acc_reg [4];
    logic                 busy_reg, valid_reg;
    res_t                 result_reg;

    // texel memory
    logic [63:0] mem [4096];
    logic [63:0] rdata_reg;
    logic        mem_we, mem_re;
    logic [11:0] mem_waddr, mem_raddr;

    logic [SIZE_BITS-1:0] w_eff, h_eff;
    logic [16:0] u_map, v_map;
    logic [32:0] mul_a;
    logic [16:0] mul_b;
    logic [49:0] mul_p;
    logic        accept;

    function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
        logic [SIZE_BITS-1:0] r;
        if (s == '0)
            r = 7'd1;
        else if (s > MAX_SIDE)
            r = MAX_SIDE;
        else
            r = s;
        return r;
    endfunction

    // fold a q7.16 coordinate into [0,1]
    function automatic logic [16:0] map_coord(input logic [UV_BITS-1:0] raw,
                                              input logic wrap);
        logic [16:0] r;
        if (wrap)
            r = {1'b0, raw[15:0]};
        else if (raw[UV_BITS-1])
            r = '0;
        else if (raw > {7'd0, ONE_Q16})
            r = ONE_Q16;
        else
            r = raw[16:0];
        return r;
    endfunction

    // clamped base index from the integer part of a scaled coordinate
    function automatic logic [SIDE_BITS-1:0] base_idx(input logic [22:0] c,
                                                      input logic [SIZE_BITS-1:0] s);
        logic [SIZE_BITS-1:0] lim;
        lim = s - 7'd1;
        return (c[22:16] > lim) ? lim[SIDE_BITS-1:0] : c[21:16];
    endfunction

    function automatic logic [SIDE_BITS-1:0] next_idx(input logic [SIDE_BITS-1:0] b,
                                                      input logic [SIZE_BITS-1:0] s);
        logic [SIZE_BITS-1:0] lim, nx;
        lim = s - 7'd1;
        nx  = {1'b0, b} + 7'd1;
        return (nx > lim) ? lim[SIDE_BITS-1:0] : nx[SIDE_BITS-1:0];
    endfunction

    function automatic logic [15:0] round_sat(input logic [48:0] a);
        logic [49:0] s;
        logic [17:0] q;
        s = {1'b0, a} + 50'h0_0000_8000_0000;
        q = s[49:32];
        return (q > 18'h0FFFF) ? 16'hFFFF ^ 16'h8000 : q[15:0] ^ 16'h8000;
    endfunction

    assign w_eff  = eff_size(width_reg);
    assign h_eff  = eff_size(height_reg);
    assign u_map  = map_coord(u_reg, wrap_reg);
    assign v_map  = map_coord(v_reg, wrap_reg);
    assign accept = start && !busy_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SCALE_U:
            begin
                mul_a = {26'd0, w_eff};
                mul_b = u_map;
            end
            S_SCALE_V:
            begin
                mul_a = {26'd0, h_eff};
                mul_b = v_map;
            end
            S_FETCH:
            begin
                mul_a = {16'd0, corner_reg[0] ? {1'b0, fx_reg} : ONE_Q16 - {1'b0, fx_reg}};
                mul_b = corner_reg[1] ? {1'b0, fy_reg} : ONE_Q16 - {1'b0, fy_reg};
            end
            S_MAC:
            begin
                mul_a = weight_reg;
                mul_b = {1'b0, rdata_reg[63 - 16*ch_reg -: 16] ^ 16'h8000};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {17'd0, mul_a} * {33'd0, mul_b};

    // store writes land in the accept cycle; sample reads one corner per fetch
    assign mem_we    = accept && (cmd.op == OP_STORE) && ({1'b0, cmd.tex_x} < w_eff)
                       && ({1'b0, cmd.tex_y} < h_eff);
    assign mem_waddr = {cmd.tex_y, cmd.tex_x};
    assign mem_re    = (state_reg == S_FETCH);
    assign mem_raddr = {corner_reg[1] ? y1_reg : y0_reg, corner_reg[0] ? x1_reg : x0_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= {cmd.in_red, cmd.in_green, cmd.in_blue, cmd.in_alpha};
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 7'd1;
            height_reg <= 7'd1;
            wrap_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_WRAP:   wrap_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            corner_reg <= '0;
            ch_reg     <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && cmd.op == OP_SAMPLE)
                    begin
                        u_reg     <= cmd.u_coord;
                        v_reg     <= cmd.v_coord;
                        busy_reg  <= 1'b1;
                        state_reg <= S_SCALE_U;
                    end
                end
                S_SCALE_U:
                begin
                    cu_reg    <= mul_p[22:0];
                    state_reg <= S_SCALE_V;
                end
                S_SCALE_V:
                begin
                    cv_reg    <= mul_p[22:0];
                    state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    x0_reg     <= base_idx(cu_reg, w_eff);
                    x1_reg     <= next_idx(base_idx(cu_reg, w_eff), w_eff);
                    y0_reg     <= base_idx(cv_reg, h_eff);
                    y1_reg     <= next_idx(base_idx(cv_reg, h_eff), h_eff);
                    fx_reg     <= cu_reg[15:0];
                    fy_reg     <= cv_reg[15:0];
                    for (int i = 0; i < 4; i++)
                        acc_reg[i] <= '0;
                    corner_reg <= '0;
                    state_reg  <= S_FETCH;
                end
                S_FETCH:
                begin
                    weight_reg <= mul_p[32:0];
                    ch_reg     <= '0;
                    state_reg  <= S_MAC;
                end
                S_MAC:
                begin
                    acc_reg[ch_reg] <= acc_reg[ch_reg] + mul_p[48:0];
                    ch_reg          <= ch_reg + 2'd1;
                    if (ch_reg == 2'd3)
                    begin
                        corner_reg <= corner_reg + 2'd1;
                        state_reg  <= (corner_reg == 2'd3) ? S_FINISH : S_FETCH;
                    end
                end
                S_FINISH:
                begin
                    result_reg.out_red   <= round_sat(acc_reg[0]);
                    result_reg.out_green <= round_sat(acc_reg[1]);
                    result_reg.out_blue  <= round_sat(acc_reg[2]);
                    result_reg.out_alpha <= round_sat(acc_reg[3]);
                    valid_reg <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = busy_reg;
    assign result_valid = valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

endmodule

/* sv/bts_checker.sv */
// ----------------------------------------------------------------------------
// bts_checker
// port-level checks on the sampler handshakes
// ----------------------------------------------------------------------------
module bts_checker
    import bts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input cmd_t cmd,
    input logic result_valid,
    input logic cfg_ready
);

    // one strobe per sample
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // result appears exactly as busy drops
    a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy dropped without a result");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result while busy");

    // a store transaction yields neither a result nor busy
    a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == OP_STORE) |=> (!result_valid && !busy))
        else $error("store transaction produced a result or busy");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config channel not ready");

endmodule

bind bilinear_texture_sampler_top bts_checker u_bts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .cfg_ready    (cfg_ready)
);
